/* rtl/core/assert_macros.svh */
// Assertion macros shared by the forwarding table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, skipped while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true on a clk edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* rtl/core/mlft_pkg.sv */
// Types and constants of the MAC learning forwarding table.
`default_nettype none

package mlft_pkg;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 4;
  localparam int AGE_W   = 8;
  localparam int STATE_W = 2;
  localparam int MASK_W  = 16;
  localparam int PCNT_W  = 5;

  localparam int TABLE_ENTRIES_DEF = 256;
  // port count is clamped to this many ports
  localparam int MAX_PORTS = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  // group (multicast) bit of the first octet
  localparam int GROUP_BIT = 40;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PORT_COUNT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_AGE_LIMIT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL_DST = 2'd2;

  localparam logic [PCNT_W-1:0] PORT_COUNT_RST  = 5'd16;
  localparam logic [AGE_W-1:0]  AGE_LIMIT_RST   = 8'd15;
  localparam logic [MAC_W-1:0]  CONTROL_DST_RST = 48'h0180_C200_0000;

  // item kinds
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // ingress port states
  localparam logic [STATE_W-1:0] ST_BLOCKED    = 2'd0;
  localparam logic [STATE_W-1:0] ST_LISTENING  = 2'd1;
  localparam logic [STATE_W-1:0] ST_LEARNING   = 2'd2;
  localparam logic [STATE_W-1:0] ST_FORWARDING = 2'd3;

  // pass carried by the token walking the cell row
  typedef enum logic [1:0] {
    PASS_SEARCH,
    PASS_INSERT,
    PASS_TICK
  } pass_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              vld;
    pass_t             pass;
    logic              flag;      // search: source found; insert: source stored
    logic              hit;       // destination found
    logic [PORT_W-1:0] hit_port;  // learned port of the destination
  } tok_t;

  // item fields broadcast to all cells while a token walks
  typedef struct packed {
    logic              learn;
    logic [PORT_W-1:0] in_port;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/mlft_cell.sv */
// One table entry: address, port and age, acting on the token as it passes.
`default_nettype none

module mlft_cell import mlft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic [AGE_W-1:0] age_limit,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [MAC_W-1:0]  mac, mac_next;
  logic [PORT_W-1:0] port, port_next;
  logic [AGE_W-1:0]  age, age_next;
  tok_t              tok_next;
  logic              ins;
  logic [MAC_W-1:0]  eff_mac;
  logic [PORT_W-1:0] eff_port;
  logic [AGE_W-1:0]  age_sat;

  // entry update and token forwarding
  always_comb begin
    mac_next  = mac;
    port_next = port;
    age_next  = age;
    tok_next  = tok_in;
    ins       = item.learn && !tok_in.flag && (mac == '0);
    eff_mac   = ins ? item.src : mac;
    eff_port  = ins ? item.in_port : port;
    age_sat   = (age == AGE_MAX) ? AGE_MAX : age + AGE_W'(1);
    if (tok_in.vld) begin
      case (tok_in.pass)
        PASS_SEARCH: begin
          // refresh an existing source entry
          if (item.learn && (mac == item.src)) begin
            port_next     = item.in_port;
            age_next      = '0;
            tok_next.flag = 1'b1;
          end
        end
        PASS_INSERT: begin
          // first empty slot takes a new source
          if (ins) begin
            mac_next      = item.src;
            port_next     = item.in_port;
            age_next      = '0;
            tok_next.flag = 1'b1;
          end
          // destination lookup sees the entry after learning
          if ((item.dst != '0) && (eff_mac == item.dst) && !tok_in.hit) begin
            tok_next.hit      = 1'b1;
            tok_next.hit_port = eff_port;
          end
        end
        PASS_TICK: begin
          if (mac != '0) begin
            if (age_sat >= age_limit) begin
              mac_next  = '0;
              port_next = '0;
              age_next  = '0;
            end else begin
              age_next = age_sat;
            end
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac         <= '0;
      port        <= '0;
      age         <= '0;
      tok_out.vld <= 1'b0;
    end else begin
      mac         <= mac_next;
      port        <= port_next;
      age         <= age_next;
      tok_out.vld <= tok_next.vld;
    end
    tok_out.pass     <= tok_next.pass;
    tok_out.flag     <= tok_next.flag;
    tok_out.hit      <= tok_next.hit;
    tok_out.hit_port <= tok_next.hit_port;
  end

endmodule

`default_nettype wire

/* rtl/core/mac_learning_forwarding_table.sv */
// Top level of the MAC learning forwarding table: control, config and cell row.
//
//   channel   dir  handshake                 payload
//   s_*       in   s_tvalid / s_tready       frame or aging tick
//   m_*       out  m_tvalid / m_tready       forwarding result
//   cfg_*     in   cfg_we (no wait)          port_count, age_limit, control_dst
//
// One item at a time. A token walks the row of TABLE_ENTRIES cells, one cell
// per cycle. A learning frame takes two walks (source search, then insert and
// destination lookup); other frames and ticks take one walk.
// Reset empties every entry at once; a stalled result holds the next item off.
`default_nettype none

module mac_learning_forwarding_table import mlft_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // dst_mac[47:0], src_mac[95:48], in_port[99:96], in_state[101:100],
  // fwd_mask[117:102], zero[119:118]
  input  logic [119:0]          s_tdata,
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_mask[15:0], dst_hit[16], src_new[17], table_full[18], is_control[19],
  // zero[23:20]
  output logic [23:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [MAC_W-1:0]      cfg_wdata
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  localparam int RES_W = 20;

  state_t             state;
  item_t              item;
  tok_t               head;
  tok_t               chain [TABLE_ENTRIES+1];
  tok_t               tail;
  logic [TABLE_ENTRIES:0] chain_vld;
  logic               found;
  logic               fwd_go;
  logic               group;
  logic [MASK_W-1:0]  others;
  logic [RES_W-1:0]   res;
  logic               ctrl_q;
  logic               launch;

  logic [PCNT_W-1:0]  port_count;
  logic [AGE_W-1:0]   age_limit;
  logic [MAC_W-1:0]   control_dst;

  // input field views
  logic [MAC_W-1:0]   in_dst;
  logic [MAC_W-1:0]   in_src;
  logic [PORT_W-1:0]  in_port;
  logic [STATE_W-1:0] in_state;
  logic [MASK_W-1:0]  in_fwd;
  logic [6:0]         pc_eff;
  logic [MASK_W-1:0]  in_use;
  logic               port_ok;
  logic               in_ctrl;
  logic               in_learn;
  logic [MASK_W-1:0]  res_mask;

  assign in_dst   = s_tdata[47:0];
  assign in_src   = s_tdata[95:48];
  assign in_port  = s_tdata[99:96];
  assign in_state = s_tdata[101:100];
  assign in_fwd   = s_tdata[117:102];

  // ports in use, clamped to the port limit
  always_comb begin
    pc_eff = (7'(port_count) > 7'(MAX_PORTS)) ? 7'(MAX_PORTS) : 7'(port_count);
    for (int i = 0; i < MASK_W; i++) begin
      in_use[i] = (7'(i) < pc_eff);
    end
  end

  assign port_ok  = (7'(in_port) < pc_eff);
  assign in_ctrl  = (in_dst == control_dst);
  assign in_learn = port_ok && (in_src != '0) &&
                    ((in_state == ST_LEARNING) || (in_state == ST_FORWARDING));

  assign s_tready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_count  <= PORT_COUNT_RST;
      age_limit   <= AGE_LIMIT_RST;
      control_dst <= CONTROL_DST_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PORT_COUNT:  port_count  <= cfg_wdata[PCNT_W-1:0];
        CFG_AGE_LIMIT:   age_limit   <= cfg_wdata[AGE_W-1:0];
        CFG_CONTROL_DST: control_dst <= cfg_wdata;
        default:         port_count  <= port_count;
      endcase
    end
  end

  // cell row
  assign chain[0] = head;
  assign tail     = chain[TABLE_ENTRIES];

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      mlft_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .item      (item),
        .age_limit (age_limit),
        .tok_in    (chain[g]),
        .tok_out   (chain[g+1])
      );
    end
    for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
      assign chain_vld[g] = chain[g].vld;
    end
  endgenerate

  // forwarding mask from the finished lookup
  always_comb begin
    res_mask = '0;
    if (fwd_go) begin
      if (group || !tail.hit) begin
        res_mask = others;
      end else begin
        res_mask = others & (MASK_W'(1) << tail.hit_port);
      end
    end
  end

  // token launch: a new item, or the insert walk after a source search
  assign launch = ((state == S_IDLE) && s_tvalid) ||
                  ((state == S_WALK) && tail.vld && (tail.pass == PASS_SEARCH));

  // sequencer: launch tokens, collect results
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head.vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      head.vld <= launch;
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            head.flag     <= 1'b0;
            head.hit      <= 1'b0;
            head.hit_port <= '0;
            found         <= 1'b0;
            if (s_tuser == OP_TICK) begin
              head.pass <= PASS_TICK;
            end else if (in_learn) begin
              head.pass <= PASS_SEARCH;
            end else begin
              head.pass <= PASS_INSERT;
            end
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (tail.vld) begin
            case (tail.pass)
              PASS_SEARCH: begin
                head.pass     <= PASS_INSERT;
                head.flag     <= tail.flag;
                head.hit      <= 1'b0;
                head.hit_port <= '0;
                found         <= tail.flag;
              end
              PASS_INSERT: begin
                res   <= {ctrl_q, item.learn && !found && !tail.flag,
                          item.learn && !found && tail.flag, tail.hit, res_mask};
                state <= S_DONE;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {4'b0, res};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture at the input transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.learn   <= (s_tuser == OP_FRAME) && in_learn;
      item.in_port <= in_port;
      item.src     <= in_src;
      item.dst     <= in_dst;
      ctrl_q       <= in_ctrl;
      group        <= in_dst[GROUP_BIT];
      fwd_go       <= port_ok && (in_state == ST_FORWARDING) && !in_ctrl;
      others       <= in_fwd & in_use & ~(MASK_W'(1) << in_port);
    end
  end

  `ASSERT_CLK(a_one_token, $onehot0(chain_vld), "more than one token in the cell row")
  `ASSERT_CLK(a_tail_walk, chain_vld[TABLE_ENTRIES] |-> (state == S_WALK), "token left the row outside a walk")
  `ASSERT_NEVER(a_new_full, m_tvalid && m_tdata[17] && m_tdata[18], "source both stored and refused")

endmodule

`default_nettype wire

/* tb/mlft_checker.sv */
// Checker for the MAC learning forwarding table: mirrors the table and checks every result.
module mlft_checker import mlft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [119:0]          s_tdata,   // dst, src, in_port, in_state, fwd_mask, zero
  input  logic                  s_tuser,   // op
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [23:0]           m_tdata,   // out_mask, dst_hit, src_new, table_full, is_control
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [MAC_W-1:0]      cfg_wdata,
  output int                    errors,
  output int                    pending,
  output int                    hits,
  output int                    learned,
  output int                    full_drops,
  output int                    control_frames
);

  typedef struct packed {
    logic [MASK_W-1:0] out_mask;
    logic              dst_hit;
    logic              src_new;
    logic              table_full;
    logic              is_control;
  } verdict_t;

  // mirrored table and registers
  logic [MAC_W-1:0]  ent_mac  [TABLE_ENTRIES_DEF];
  logic [PORT_W-1:0] ent_port [TABLE_ENTRIES_DEF];
  logic [AGE_W-1:0]  ent_age  [TABLE_ENTRIES_DEF];
  logic [PCNT_W-1:0] port_count;
  logic [AGE_W-1:0]  age_limit;
  logic [MAC_W-1:0]  control_dst;

  // verdicts of accepted items, oldest first
  verdict_t expected_verdicts[$];

  function automatic int lookup(input logic [MAC_W-1:0] mac);
    int i;
    if (mac == '0) return -1;
    for (i = 0; i < TABLE_ENTRIES_DEF; i++)
      if (ent_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic logic [MASK_W-1:0] ports_in_use();
    logic [PCNT_W-1:0] pc;
    logic [MASK_W:0]   span;
    pc = (port_count > MAX_PORTS) ? PCNT_W'(MAX_PORTS) : port_count;
    span = ((MASK_W+1)'(1) << pc) - (MASK_W+1)'(1);
    return span[MASK_W-1:0];
  endfunction

  // aging tick: bump every live entry, drop the ones at the limit
  function automatic void age_entries();
    int i;
    for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (ent_mac[i] != '0) begin
        if (ent_age[i] != AGE_MAX) ent_age[i] = ent_age[i] + 1'b1;
        if (ent_age[i] >= age_limit) begin
          ent_mac[i]  = '0;
          ent_port[i] = '0;
          ent_age[i]  = '0;
        end
      end
    end
  endfunction

  // frame: learn the source, then look up the destination and pick egress ports
  function automatic verdict_t decide_frame(input logic [MAC_W-1:0] dst,
                                            input logic [MAC_W-1:0] src,
                                            input logic [PORT_W-1:0] port,
                                            input logic [STATE_W-1:0] state,
                                            input logic [MASK_W-1:0] fwd);
    verdict_t          v;
    logic [MASK_W-1:0] in_use;
    logic [MASK_W-1:0] others;
    logic              port_ok;
    int                slot;
    int                i;
    v = '0;
    in_use = ports_in_use();
    port_ok = in_use[port];
    v.is_control = (dst == control_dst);
    if (port_ok && (state == ST_LEARNING || state == ST_FORWARDING) && src != '0) begin
      slot = lookup(src);
      if (slot >= 0) begin
        ent_port[slot] = port;
        ent_age[slot]  = '0;
      end else begin
        // first empty slot wins
        for (i = TABLE_ENTRIES_DEF - 1; i >= 0; i--)
          if (ent_mac[i] == '0) slot = i;
        if (slot >= 0) begin
          ent_mac[slot]  = src;
          ent_port[slot] = port;
          ent_age[slot]  = '0;
          v.src_new = 1'b1;
        end else begin
          v.table_full = 1'b1;
        end
      end
    end
    slot = lookup(dst);
    v.dst_hit = (slot >= 0);
    if (port_ok && state == ST_FORWARDING && !v.is_control) begin
      others = fwd & in_use & ~(MASK_W'(1) << port);
      if (dst[GROUP_BIT] || slot < 0) v.out_mask = others;
      else v.out_mask = others & (MASK_W'(1) << ent_port[slot]);
    end
    return v;
  endfunction

  function automatic void compare_field(input string name, input logic [MASK_W-1:0] want,
                                        input logic [MASK_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    int       i;
    if (rst) begin
      for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
        ent_mac[i]  = '0;
        ent_port[i] = '0;
        ent_age[i]  = '0;
      end
      port_count  = PORT_COUNT_RST;
      age_limit   = AGE_LIMIT_RST;
      control_dst = CONTROL_DST_RST;
      expected_verdicts.delete();
      pending = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PORT_COUNT:  port_count  = cfg_wdata[PCNT_W-1:0];
          CFG_AGE_LIMIT:   age_limit   = cfg_wdata[AGE_W-1:0];
          CFG_CONTROL_DST: control_dst = cfg_wdata;
          default: ;
        endcase
      end
      // result transfer
      if (m_tvalid && m_tready) begin
        got.out_mask   = m_tdata[15:0];
        got.dst_hit    = m_tdata[16];
        got.src_new    = m_tdata[17];
        got.table_full = m_tdata[18];
        got.is_control = m_tdata[19];
        if (expected_verdicts.size() == 0) begin
          $error("result transfer with nothing outstanding: m_tdata 'h%0h", m_tdata);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          pending--;
          compare_field("out_mask", want.out_mask, got.out_mask);
          compare_field("dst_hit", MASK_W'(want.dst_hit), MASK_W'(got.dst_hit));
          compare_field("src_new", MASK_W'(want.src_new), MASK_W'(got.src_new));
          compare_field("table_full", MASK_W'(want.table_full), MASK_W'(got.table_full));
          compare_field("is_control", MASK_W'(want.is_control), MASK_W'(got.is_control));
          if (want.dst_hit) hits++;
          if (want.src_new) learned++;
          if (want.table_full) full_drops++;
          if (want.is_control) control_frames++;
        end
      end
      // item transfer
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_TICK) begin
          age_entries();
          want = '0;
        end else begin
          want = decide_frame(s_tdata[47:0], s_tdata[95:48], s_tdata[99:96],
                              s_tdata[101:100], s_tdata[117:102]);
        end
        expected_verdicts.push_back(want);
        pending++;
      end
    end
  end

endmodule

/* tb/mac_learning_forwarding_table_tb.sv */
// Testbench top for the MAC learning forwarding table: clock, reset, stimulus and verdict.
module mac_learning_forwarding_table_tb;
  import mlft_pkg::*;

  localparam int LIMIT   = 5_000_000;
  localparam int GAP_MAX = 2 * TABLE_ENTRIES_DEF + 8;

  localparam logic [MAC_W-1:0] MAC_A     = 48'h0200_0000_00A1;
  localparam logic [MAC_W-1:0] MAC_B     = 48'h0200_0000_00B2;
  localparam logic [MAC_W-1:0] MAC_C     = 48'h02C0_FFEE_00C3;
  localparam logic [MAC_W-1:0] MAC_D     = 48'h0A00_0000_00D4;
  localparam logic [MAC_W-1:0] MAC_E     = 48'h0E00_0000_00E5;
  localparam logic [MAC_W-1:0] MAC_F     = 48'h0200_1234_56F6;
  localparam logic [MAC_W-1:0] MAC_GROUP = 48'h0100_5E00_0001;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [119:0]          s_tdata   = '0;
  logic                  s_tuser   = OP_FRAME;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_PORT_COUNT;
  logic [MAC_W-1:0]      cfg_wdata = '0;

  int errors, pending, hits, learned, full_drops, control_frames;
  int cycles   = 0;
  int frames   = 0;
  int ticks    = 0;
  int settings = 0;

  logic              idle_on   = 1'b1;
  logic [PCNT_W-1:0] cur_ports = PORT_COUNT_RST;
  logic [MAC_W-1:0]  cur_ctrl  = CONTROL_DST_RST;
  logic [MAC_W-1:0]  mac_pool [16];

  mac_learning_forwarding_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  mlft_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .hits(hits), .learned(learned),
    .full_drops(full_drops), .control_frames(control_frames)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !idle_on || ($urandom_range(99) >= 35);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("mac_learning_forwarding_table_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // one item transfer, after an optional idle gap
  task automatic send_item(input logic op, input logic [MAC_W-1:0] dst,
                           input logic [MAC_W-1:0] src, input logic [PORT_W-1:0] port,
                           input logic [STATE_W-1:0] state, input logic [MASK_W-1:0] fwd);
    int gap;
    gap = (idle_on && $urandom_range(99) < 35) ? $urandom_range(1, GAP_MAX) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, fwd, state, port, src, dst};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_TICK) ticks++;
    else frames++;
  endtask

  task automatic frame(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
                       input logic [PORT_W-1:0] port, input logic [STATE_W-1:0] state,
                       input logic [MASK_W-1:0] fwd);
    send_item(OP_FRAME, dst, src, port, state, fwd);
  endtask

  // frame fields are don't-care on a tick, so fill them with noise
  task automatic tick();
    send_item(OP_TICK, rand_mac(), rand_mac(), PORT_W'($urandom_range(15)),
              STATE_W'($urandom_range(3)), MASK_W'($urandom));
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  // write all three registers while the block is idle; junk above the field width
  task automatic configure(input logic [PCNT_W-1:0] pc, input logic [AGE_W-1:0] al,
                           input logic [MAC_W-1:0] cd);
    logic [MAC_W-1:0] junk;
    settle();
    junk = rand_mac();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PORT_COUNT;
    cfg_wdata <= {junk[MAC_W-1:PCNT_W], pc};
    @(posedge clk);
    cfg_addr  <= CFG_AGE_LIMIT;
    cfg_wdata <= {junk[MAC_W-1:AGE_W], al};
    @(posedge clk);
    cfg_addr  <= CFG_CONTROL_DST;
    cfg_wdata <= cd;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ports = pc;
    cur_ctrl  = cd;
    settings++;
  endtask

  // random item biased toward a small address pool so entries get hit and refreshed
  task automatic rand_item(input int tick_pct);
    logic [MAC_W-1:0]   dst;
    logic [MAC_W-1:0]   src;
    logic [PORT_W-1:0]  port;
    logic [STATE_W-1:0] state;
    logic [MASK_W-1:0]  fwd;
    int                 r;
    int                 lim;
    if ($urandom_range(99) < tick_pct) begin
      tick();
      return;
    end
    r = $urandom_range(99);
    if (r < 65) dst = mac_pool[$urandom_range(15)];
    else if (r < 75) dst = cur_ctrl;
    else if (r < 80) dst = '0;
    else dst = rand_mac();
    r = $urandom_range(99);
    if (r < 75) src = mac_pool[$urandom_range(15)];
    else if (r < 80) src = '0;
    else src = rand_mac();
    lim = (cur_ports > MAX_PORTS) ? MAX_PORTS : cur_ports;
    if (lim > 0 && $urandom_range(99) < 80) port = PORT_W'($urandom_range(lim - 1));
    else port = PORT_W'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 60) state = ST_FORWARDING;
    else if (r < 80) state = ST_LEARNING;
    else if (r < 90) state = ST_BLOCKED;
    else state = ST_LISTENING;
    r = $urandom_range(99);
    if (r < 50) fwd = MASK_W'($urandom);
    else if (r < 75) fwd = '1;
    else fwd = MASK_W'($urandom & $urandom & $urandom);
    frame(dst, src, port, state, fwd);
  endtask

  initial begin : stimulus
    logic [MAC_W-1:0] src;
    logic [MAC_W-1:0] prev_src;
    int               i;
    int               p;
    int               n;

    // pool: mostly unicast, a few group addresses
    for (i = 0; i < 16; i++) begin
      mac_pool[i] = rand_mac();
      mac_pool[i][GROUP_BIT] = (i >= 12);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: forwarding rules and special addresses under reset settings
    tick();                                                  // aging an empty table
    frame(MAC_B, MAC_A, 4'd3, ST_FORWARDING, '1);            // unknown dst floods
    frame(MAC_A, MAC_B, 4'd7, ST_FORWARDING, '1);            // known dst: port 3 only
    frame(MAC_A, MAC_A, 4'd3, ST_FORWARDING, '1);            // learned port is ingress
    frame(MAC_B, MAC_C, 4'd1, ST_FORWARDING, 16'hFF7F);      // learned port not forwarding
    frame(MAC_GROUP, MAC_A, 4'd3, ST_FORWARDING, 16'h00F0);  // group dst floods
    frame(CONTROL_DST_RST, MAC_D, 4'd5, ST_FORWARDING, '1);  // control frame kept local
    frame(MAC_A, MAC_E, 4'd9, ST_BLOCKED, '1);
    frame(MAC_A, MAC_E, 4'd9, ST_LISTENING, '1);
    frame(MAC_A, MAC_E, 4'd9, ST_LEARNING, '1);              // learns, never sends
    frame(MAC_E, '0, 4'd2, ST_FORWARDING, '1);               // zero source not learned
    frame('0, MAC_C, 4'd0, ST_FORWARDING, 16'h0001);         // zero dst is unknown
    frame('1, '1, 4'd15, ST_FORWARDING, '1);                 // broadcast, all-ones source
    frame('1, MAC_A, 4'd0, ST_FORWARDING, '1);               // known group dst still floods
    frame(MAC_B, MAC_D, 4'd15, ST_FORWARDING, '0);           // nothing forwarding
    configure(5'd4, 8'd2, '0);
    frame(MAC_A, MAC_F, 4'd9, ST_FORWARDING, '1);            // ingress port not in use
    frame('0, MAC_F, 4'd1, ST_FORWARDING, '1);               // zero dst is now control
    tick();
    tick();                                                  // age limit reached
    frame(MAC_A, MAC_F, 4'd2, ST_FORWARDING, '1);            // A aged out

    // fill the table until inserts are refused, then empty it again
    configure(5'd16, 8'd1, CONTROL_DST_RST);
    tick();
    configure(5'd16, 8'd255, CONTROL_DST_RST);
    prev_src = MAC_A;
    for (i = 0; i < TABLE_ENTRIES_DEF + 8; i++) begin
      src = {8'h02, 8'($urandom), 16'($urandom), 16'(i + 1)};
      frame(($urandom_range(3) == 0) ? rand_mac() : prev_src, src,
            PORT_W'($urandom_range(15)),
            ($urandom_range(1) == 0) ? ST_LEARNING : ST_FORWARDING, MASK_W'($urandom));
      prev_src = src;
    end
    frame(src, prev_src, 4'd6, ST_FORWARDING, '1);            // unlearned source still refused when full
    configure(5'd16, 8'd1, CONTROL_DST_RST);
    tick();

    // random phases over a range of settings
    for (p = 0; p < 7; p++) begin
      case (p)
        0: configure(5'd16, 8'd4, rand_mac());
        1: configure(5'd5, 8'd2, rand_mac());
        2: configure(5'd1, 8'd1, '1);
        3: configure(5'd0, 8'd3, '0);
        4: configure(5'd31, 8'd255, rand_mac());
        5: configure(PCNT_W'($urandom_range(17, 30)), 8'd0, CONTROL_DST_RST);
        default: configure(PCNT_W'($urandom_range(1, 16)), AGE_W'($urandom_range(1, 8)),
                           rand_mac());
      endcase
      idle_on = (p != 4);
      for (n = 0; n < 115; n++) rand_item((p == 4) ? 4 : 8);
      idle_on = 1'b1;
    end

    settle();
    $display("Sent %0d frames and %0d aging ticks under %0d register settings,",
             frames, ticks, settings);
    $display("  with %0d destination hits, %0d sources learned, %0d refused inserts, %0d control.",
             hits, learned, full_drops, control_frames);
    if (errors == 0 && pending == 0)
      $display("mac_learning_forwarding_table_tb OK");
    else
      $display("mac_learning_forwarding_table_tb NOT OK");
    $finish;
  end

endmodule
